/* hw/rtl/neighbour_table_with_timeout_top_defines.svh */
// Assertion helpers shared by the neighbour table RTL.
// Each macro expects clk and arst_n in scope.
`ifndef NEIGHBOUR_TABLE_WITH_TIMEOUT_TOP_DEFINES_SVH
`define NEIGHBOUR_TABLE_WITH_TIMEOUT_TOP_DEFINES_SVH

// Same-cycle implication.
`define NBT_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("neighbour table check failed");

// Next-cycle implication.
`define NBT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("neighbour table check failed");

`endif

/* hw/rtl/nbt_pkg.sv */
`timescale 1ns / 1ps
package nbt_pkg;

	// request codes
	typedef enum logic [2:0] {
		ACT_ADD    = 3'd0,
		ACT_FIND   = 3'd1,
		ACT_REMOVE = 3'd2,
		ACT_TURN   = 3'd3,
		ACT_FLAGS  = 3'd4
	} action_t;

	// result status codes
	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_FULL     = 2'd1;
	localparam logic [1:0] STAT_NO_ENTRY = 2'd2;

	// reset value of the timeout threshold
	localparam logic [7:0] TIMEOUT_TURNS_RESET = 8'd3;

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	// one neighbour slot
	typedef struct packed {
		logic [31:0] addr;
		logic [7:0]  unreached;
		logic        reached;
		logic        timed_out;
	} entry_t;

	// write command for one cell
	typedef struct packed {
		logic   en;
		entry_t data;
	} cell_wr_t;

endpackage

/* hw/rtl/neighbour_table_with_timeout_top.sv */
`timescale 1ns / 1ps
// Neighbour table with aging timeout.
// Input channel (in_valid/in_ready) takes one request: action, address,
// entry_index and the two flag values. Output channel (out_valid/out_ready)
// returns exactly one result per request: result_index, hit, alive, status
// and entry_count after the action.
// Config channel (cfg_valid/cfg_ready) writes timeout_turns; it is always
// ready and should only be written while no request is in flight.
// An accepted request is first captured into the request registers; in the
// execute state all cells then compare the address in parallel, the single
// slot write is applied and the result is loaded into the output register.
// A new request is taken only after the previous one has left execute.
// The slots form a row of cells, one per entry; each compares its address
// and takes the write command addressed to it.
// Reset clears the entry count, the pending request and the output; the
// threshold returns to 3. Slot contents are not cleared (slots above the
// count are never read). When the receiver stalls, the finished result is
// held and the next request may still be captured; it then waits in the
// execute cycle until the output register frees.
module neighbour_table_with_timeout_top
	import nbt_pkg::*;
#(
	parameter int MAX_ENTRIES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  action,
	input  logic [31:0] address,
	input  logic [3:0]  entry_index,
	input  logic        reached_value,
	input  logic        timed_out_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  result_index,
	output logic        hit,
	output logic        alive,
	output logic [1:0]  status,
	output logic [4:0]  entry_count,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data
);

`include "neighbour_table_with_timeout_top_defines.svh"

	localparam int IDX_W = $clog2(MAX_ENTRIES);
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int CMP_W = CNT_W + 4;
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTRIES);

	state_t           state_q, state_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [7:0]       timeout_q;

	// captured request
	logic [2:0]  act_q;
	logic [31:0] addr_q;
	logic [3:0]  idx_q;
	logic        rv_q, tv_q;

	// output register
	logic        out_valid_q;
	logic [3:0]  res_index_q, res_index_d;
	logic        hit_q, hit_d;
	logic        alive_q, alive_d;
	logic [1:0]  status_q, status_d;

	entry_t   cell_ent [MAX_ENTRIES];
	logic     cell_match [MAX_ENTRIES];
	cell_wr_t cell_wr [MAX_ENTRIES];

	logic             exec_go;
	logic             wr_en;
	logic [IDX_W-1:0] wr_slot;
	entry_t           wr_data;

	// row of slot cells
	for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
		nbt_cell u_cell (
			.clk   (clk),
			.wr    (cell_wr[g]),
			.key   (addr_q),
			.ent   (cell_ent[g]),
			.match (cell_match[g])
		);
		assign cell_wr[g].en   = wr_en && (wr_slot == IDX_W'(g));
		assign cell_wr[g].data = wr_data;
	end

	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign exec_go   = (state_q == S_EXEC) && (!out_valid_q || out_ready);

	// execute: search, select slots, compute update and result
	always_comb begin
		logic             found;
		logic [IDX_W-1:0] found_slot;
		entry_t           ent_sel;
		entry_t           ent_last;
		entry_t           ent_upd;
		logic [CNT_W-1:0] last_cnt;
		logic [CMP_W-1:0] idx_ext;
		logic [CMP_W-1:0] cnt_ext;
		logic [IDX_W+3:0] slot_wide;
		logic [7:0]       next_unr;

		found      = 1'b0;
		found_slot = '0;
		ent_sel    = '0;
		ent_last   = '0;
		last_cnt   = count_q - CNT_W'(1);
		idx_ext    = CMP_W'(idx_q);
		cnt_ext    = CMP_W'(count_q);

		for (int i = 0; i < MAX_ENTRIES; i++) begin
			if (cell_match[i] && (CNT_W'(i) < count_q)) begin
				found      = 1'b1;
				found_slot = found_slot | IDX_W'(i);
			end
			if (idx_ext == CMP_W'(i)) begin
				ent_sel = entry_t'(ent_sel | cell_ent[i]);
			end
			if (last_cnt == CNT_W'(i)) begin
				ent_last = entry_t'(ent_last | cell_ent[i]);
			end
		end

		count_d     = count_q;
		wr_en       = 1'b0;
		wr_slot     = IDX_W'(idx_q);
		wr_data     = ent_sel;
		res_index_d = 4'd0;
		hit_d       = 1'b0;
		alive_d     = 1'b0;
		status_d    = STAT_OK;
		ent_upd     = ent_sel;
		next_unr    = ent_sel.unreached + 8'd1;
		slot_wide   = '0;

		unique case (act_q) inside
			ACT_ADD, ACT_FIND: begin
				if (found) begin
					hit_d     = 1'b1;
					slot_wide = (IDX_W+4)'(found_slot);
				end else if (act_q == ACT_ADD) begin
					if (count_q >= MAX_CNT) begin
						status_d = STAT_FULL;
					end else begin
						wr_en     = 1'b1;
						wr_slot   = count_q[IDX_W-1:0];
						wr_data   = '{addr: addr_q, unreached: 8'd0,
							reached: 1'b0, timed_out: 1'b0};
						count_d   = count_q + CNT_W'(1);
						slot_wide = (IDX_W+4)'(count_q[IDX_W-1:0]);
					end
				end
				res_index_d = slot_wide[3:0];
			end
			ACT_REMOVE, ACT_TURN, ACT_FLAGS: begin
				res_index_d = idx_q;
				if (idx_ext >= cnt_ext) begin
					status_d = STAT_NO_ENTRY;
				end else if (act_q == ACT_REMOVE) begin
					// move the last slot into the removed one
					count_d = last_cnt;
					wr_en   = 1'b1;
					wr_data = ent_last;
				end else if (act_q == ACT_TURN) begin
					alive_d = 1'b1;
					if (ent_sel.timed_out) begin
						wr_en = 1'b0;
					end else if (ent_sel.reached) begin
						ent_upd.reached   = 1'b0;
						ent_upd.unreached = 8'd0;
						wr_en             = 1'b1;
					end else begin
						wr_en = 1'b1;
						if (next_unr == timeout_q) begin
							ent_upd.unreached = 8'd0;
							alive_d           = 1'b0;
						end else begin
							ent_upd.unreached = next_unr;
						end
					end
					wr_data = ent_upd;
				end else begin
					ent_upd.reached   = rv_q;
					ent_upd.timed_out = tv_q;
					wr_en             = 1'b1;
					wr_data           = ent_upd;
				end
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase

		// drop the write unless the step really executes
		if (!exec_go) begin
			wr_en   = 1'b0;
			count_d = count_q;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (in_valid) state_d = S_EXEC;
			S_EXEC: if (exec_go) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			timeout_q   <= TIMEOUT_TURNS_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (cfg_valid) begin
				timeout_q <= cfg_data;
			end
			if (exec_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// capture the request, load the result
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			act_q  <= action;
			addr_q <= address;
			idx_q  <= entry_index;
			rv_q   <= reached_value;
			tv_q   <= timed_out_value;
		end
		if (exec_go) begin
			res_index_q <= res_index_d;
			hit_q       <= hit_d;
			alive_q     <= alive_d;
			status_q    <= status_d;
		end
	end

	// result ports
	logic [CNT_W+4:0] count_wide;
	assign count_wide   = (CNT_W+5)'(count_q);
	assign out_valid    = out_valid_q;
	assign result_index = res_index_q;
	assign hit          = hit_q;
	assign alive        = alive_q;
	assign status       = status_q;
	assign entry_count  = count_wide[4:0];

	`NBT_ASSERT_IMPL(a_count_bound, 1'b1, count_q <= MAX_CNT)
	`NBT_ASSERT_NEXT(a_accept_exec, in_valid && in_ready, state_q == S_EXEC)
	`NBT_ASSERT_IMPL(a_full_state, out_valid_q && (status_q == STAT_FULL), !hit_q && (count_q == MAX_CNT))
	`NBT_ASSERT_NEXT(a_count_hold, !exec_go, $stable(count_q))

endmodule

/* hw/rtl/nbt_cell.sv */
`timescale 1ns / 1ps
module nbt_cell
	import nbt_pkg::*;
(
	input  logic        clk,
	input  cell_wr_t    wr,
	input  logic [31:0] key,
	output entry_t      ent,
	output logic        match
);

	entry_t ent_q;

	// hold the slot, load on write command
	always_ff @(posedge clk) begin
		if (wr.en) begin
			ent_q <= wr.data;
		end
	end

	// compare the stored address against the searched one
	assign match = (ent_q.addr == key);
	assign ent   = ent_q;

endmodule
